### design/tlt_pkg.sv
// Shared constants and codes of the tensor layout transposer.
`default_nettype none

package tlt_pkg;

    // Buffer depth in elements and the largest tensor dimension.
    localparam int MAX_ELEMENTS = 4096;
    localparam int DIM_MAX      = 64;

    // Derived widths.
    localparam int CNT_W   = $clog2(DIM_MAX);          // loop counter
    localparam int DIM_W   = CNT_W + 1;                // dimension register
    localparam int ADDR_W  = $clog2(MAX_ELEMENTS);     // buffer address
    localparam int WIDX_W  = ADDR_W + 1;               // write index, holds the depth itself
    localparam int PLANE_W = 2 * CNT_W + 1;            // product of two dimensions
    localparam int TOTAL_W = PLANE_W + DIM_W;          // product of three dimensions
    localparam int FULL_W  = 3 * CNT_W;                // unclipped read address
    localparam int DATA_W  = 8;

    // Cycles that the stride and size products need after a register write.
    localparam int SETTLE_CYCLES = 2;
    localparam int SETTLE_W      = $clog2(SETTLE_CYCLES + 1);

    typedef enum logic [1:0] {
        CFG_HEIGHT    = 2'd0,
        CFG_WIDTH     = 2'd1,
        CFG_CHANNELS  = 2'd2,
        CFG_DIRECTION = 2'd3
    } cfg_index_t;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_DRAIN = 1'b1
    } cmd_t;

    typedef enum logic {
        DIR_HWC_TO_CHW = 1'b0,
        DIR_CHW_TO_HWC = 1'b1
    } direction_t;

endpackage

`default_nettype wire

### design/tlt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module tlt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### design/tensor_layout_transposer_core.sv
// Top level of the tensor layout transposer: HWC/CHW reordering through an element buffer.
`default_nettype none

// The block buffers one 3-D tensor of signed 8-bit elements and plays it back in the
// other layout. A load transfer writes the next element into the buffer in arrival
// order; a drain transfer reads one element in the permuted order and returns it as
// one result transfer, with last_element set on the final element of the tensor and
// size_error set when height*width*channels exceeds the buffer. Every item costs one
// buffer access, so the block takes one item per cycle unless the input is stalled: a
// load is one RAM write, a drain is one RAM read whose registered data then enters the
// output register once the result channel can take it. After any register write the
// input stalls while the stride and size products are recomputed in their registers;
// configuration writes themselves are always taken. Dimension registers read as 0 are
// used as 1, values above 64 as 64. The buffer has no clearing pass: an entry that
// was never loaded reads as an undefined value.
module tensor_layout_transposer_core (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // Configuration write port.
    input  wire logic                       cfg_wr_en,
    input  wire tlt_pkg::cfg_index_t        cfg_index,
    input  wire logic [tlt_pkg::DIM_W-1:0]  cfg_data,
    // Input channel.
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire tlt_pkg::cmd_t              cmd,
    input  wire logic signed [tlt_pkg::DATA_W-1:0] data_in,
    // Result channel.
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic signed [tlt_pkg::DATA_W-1:0] data_out,
    output logic                            last_element,
    output logic                            size_error
);

    import tlt_pkg::*;

    // Configuration registers.
    logic [DIM_W-1:0]  height_reg;
    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  channels_reg;
    direction_t        direction_reg;

    // Dimensions after clamping into 1..DIM_MAX.
    logic [DIM_W-1:0]  h_dim;
    logic [DIM_W-1:0]  w_dim;
    logic [DIM_W-1:0]  c_dim;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (v > DIM_W'(DIM_MAX))
        begin
            r = DIM_W'(DIM_MAX);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    assign h_dim = clamp_dim(height_reg);
    assign w_dim = clamp_dim(width_reg);
    assign c_dim = clamp_dim(channels_reg);

    // Plane products and the size check, each a single multiply behind a register.
    logic [2*DIM_W-1:0]         hw_prod;
    logic [2*DIM_W-1:0]         wc_prod;
    logic [PLANE_W+DIM_W-1:0]   total_prod;
    logic [PLANE_W-1:0]         hw_reg;
    logic [PLANE_W-1:0]         wc_reg;
    logic                       size_err_reg;

    assign hw_prod    = h_dim * w_dim;
    assign wc_prod    = w_dim * c_dim;
    assign total_prod = hw_reg * c_dim;

    always_ff @(posedge clk)
    begin
        hw_reg       <= hw_prod[PLANE_W-1:0];
        wc_reg       <= wc_prod[PLANE_W-1:0];
        size_err_reg <= (total_prod[TOTAL_W-1:0] > TOTAL_W'(MAX_ELEMENTS));
    end

    // While the products above settle after a register write, no item is taken.
    logic [SETTLE_W-1:0] settle_reg;
    logic [SETTLE_W-1:0] settle_next;

    // Loop bounds and the address stride of each loop level. In HWC to CHW the loops
    // are channel, row, column and the address is row*W*C + column*C + channel. In
    // CHW to HWC they are row, column, channel and the address is
    // channel*H*W + row*W + column.
    logic [DIM_W-1:0]   n_outer;
    logic [DIM_W-1:0]   n_middle;
    logic [DIM_W-1:0]   n_inner;
    logic [PLANE_W-1:0] s_outer;
    logic [PLANE_W-1:0] s_middle;
    logic [PLANE_W-1:0] s_inner;

    always_comb
    begin
        unique case (direction_reg)
            DIR_HWC_TO_CHW:
            begin
                n_outer  = c_dim;
                n_middle = h_dim;
                n_inner  = w_dim;
                s_outer  = PLANE_W'(1);
                s_middle = wc_reg;
                s_inner  = PLANE_W'(c_dim);
            end
            DIR_CHW_TO_HWC:
            begin
                n_outer  = h_dim;
                n_middle = w_dim;
                n_inner  = c_dim;
                s_outer  = PLANE_W'(w_dim);
                s_middle = PLANE_W'(1);
                s_inner  = hw_reg;
            end
            default:
            begin
                n_outer  = c_dim;
                n_middle = h_dim;
                n_inner  = w_dim;
                s_outer  = PLANE_W'(1);
                s_middle = wc_reg;
                s_inner  = PLANE_W'(c_dim);
            end
        endcase
    end

    // Progress state: write index, loop counters and the running address term of
    // each loop level, so that the read address is a three-way sum with no multiply.
    logic [WIDX_W-1:0] write_index_reg;
    logic [WIDX_W-1:0] write_index_next;
    logic [CNT_W-1:0]  outer_reg;
    logic [CNT_W-1:0]  outer_next;
    logic [CNT_W-1:0]  middle_reg;
    logic [CNT_W-1:0]  middle_next;
    logic [CNT_W-1:0]  inner_reg;
    logic [CNT_W-1:0]  inner_next;
    logic [FULL_W-1:0] t_outer_reg;
    logic [FULL_W-1:0] t_outer_next;
    logic [FULL_W-1:0] t_middle_reg;
    logic [FULL_W-1:0] t_middle_next;
    logic [FULL_W-1:0] t_inner_reg;
    logic [FULL_W-1:0] t_inner_next;

    logic [DIM_W-1:0]  outer_end;
    logic [DIM_W-1:0]  middle_end;
    logic [DIM_W-1:0]  inner_end;
    logic              outer_at_end;
    logic              middle_at_end;
    logic              inner_at_end;
    logic              last_item;
    logic [FULL_W-1:0] read_address;
    logic              read_in_range;

    assign outer_end     = n_outer - DIM_W'(1);
    assign middle_end    = n_middle - DIM_W'(1);
    assign inner_end     = n_inner - DIM_W'(1);
    assign outer_at_end  = (outer_reg == outer_end[CNT_W-1:0]);
    assign middle_at_end = (middle_reg == middle_end[CNT_W-1:0]);
    assign inner_at_end  = (inner_reg == inner_end[CNT_W-1:0]);
    assign last_item     = outer_at_end && middle_at_end && inner_at_end;

    assign read_address  = t_outer_reg + t_middle_reg + t_inner_reg;
    assign read_in_range = (read_address < FULL_W'(MAX_ELEMENTS));

    // Handshake. The read stage holds one drain result until the output register
    // can take it; while it is blocked, the buffer read data must not move, so
    // nothing is accepted.
    logic p1_valid_reg;
    logic p1_last_reg;
    logic p1_err_reg;
    logic p1_oob_reg;
    logic out_valid_reg;
    logic p1_advance;
    logic in_accept;
    logic load_accept;
    logic drain_accept;
    logic buffer_write;

    assign p1_advance   = p1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall     = (settle_reg != '0) || (p1_valid_reg && !p1_advance);
    assign in_accept    = in_valid && !in_stall;
    assign load_accept  = in_accept && (cmd == CMD_LOAD);
    assign drain_accept = in_accept && (cmd == CMD_DRAIN);
    assign buffer_write = load_accept && (write_index_reg < WIDX_W'(MAX_ELEMENTS));

    always_comb
    begin
        write_index_next = write_index_reg;
        outer_next       = outer_reg;
        middle_next      = middle_reg;
        inner_next       = inner_reg;
        t_outer_next     = t_outer_reg;
        t_middle_next    = t_middle_reg;
        t_inner_next     = t_inner_reg;

        if (cfg_wr_en || (drain_accept && last_item))
        begin
            // A register write or the end of the tensor starts a new tensor.
            write_index_next = '0;
            outer_next       = '0;
            middle_next      = '0;
            inner_next       = '0;
            t_outer_next     = '0;
            t_middle_next    = '0;
            t_inner_next     = '0;
        end
        else if (drain_accept)
        begin
            if (!inner_at_end)
            begin
                inner_next   = inner_reg + CNT_W'(1);
                t_inner_next = t_inner_reg + FULL_W'(s_inner);
            end
            else
            begin
                inner_next   = '0;
                t_inner_next = '0;
                if (!middle_at_end)
                begin
                    middle_next   = middle_reg + CNT_W'(1);
                    t_middle_next = t_middle_reg + FULL_W'(s_middle);
                end
                else
                begin
                    middle_next   = '0;
                    t_middle_next = '0;
                    outer_next    = outer_reg + CNT_W'(1);
                    t_outer_next  = t_outer_reg + FULL_W'(s_outer);
                end
            end
        end
        else if (buffer_write)
        begin
            write_index_next = write_index_reg + WIDX_W'(1);
        end
    end

    always_comb
    begin
        if (cfg_wr_en)
        begin
            settle_next = SETTLE_W'(SETTLE_CYCLES);
        end
        else if (settle_reg != '0)
        begin
            settle_next = settle_reg - SETTLE_W'(1);
        end
        else
        begin
            settle_next = settle_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_reg      <= DIM_W'(1);
            width_reg       <= DIM_W'(1);
            channels_reg    <= DIM_W'(1);
            direction_reg   <= DIR_HWC_TO_CHW;
            settle_reg      <= SETTLE_W'(SETTLE_CYCLES);
            write_index_reg <= '0;
            outer_reg       <= '0;
            middle_reg      <= '0;
            inner_reg       <= '0;
            t_outer_reg     <= '0;
            t_middle_reg    <= '0;
            t_inner_reg     <= '0;
            p1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    CFG_HEIGHT:    height_reg    <= cfg_data;
                    CFG_WIDTH:     width_reg     <= cfg_data;
                    CFG_CHANNELS:  channels_reg  <= cfg_data;
                    CFG_DIRECTION: direction_reg <= direction_t'(cfg_data[0]);
                    default:       height_reg    <= height_reg;
                endcase
            end
            settle_reg      <= settle_next;
            write_index_reg <= write_index_next;
            outer_reg       <= outer_next;
            middle_reg      <= middle_next;
            inner_reg       <= inner_next;
            t_outer_reg     <= t_outer_next;
            t_middle_reg    <= t_middle_next;
            t_inner_reg     <= t_inner_next;

            if (drain_accept)
            begin
                p1_valid_reg <= 1'b1;
            end
            else if (p1_advance)
            begin
                p1_valid_reg <= 1'b0;
            end

            if (p1_advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Element buffer.
    logic [DATA_W-1:0] buffer_rdata;

    tlt_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_ELEMENTS)
    ) u_buffer (
        .clk   (clk),
        .we    (buffer_write),
        .waddr (write_index_reg[ADDR_W-1:0]),
        .wdata (data_in),
        .re    (drain_accept),
        .raddr (read_address[ADDR_W-1:0]),
        .rdata (buffer_rdata)
    );

    // Payload of the read stage and of the output register.
    logic signed [DATA_W-1:0] data_out_reg;
    logic                     last_reg;
    logic                     err_reg;

    always_ff @(posedge clk)
    begin
        if (drain_accept)
        begin
            p1_last_reg <= last_item;
            p1_err_reg  <= size_err_reg;
            p1_oob_reg  <= !read_in_range;
        end
        if (p1_advance)
        begin
            // An address past the end of the buffer, possible only with a size
            // error, returns zero.
            data_out_reg <= p1_oob_reg ? '0 : $signed(buffer_rdata);
            last_reg     <= p1_last_reg;
            err_reg      <= p1_err_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign data_out     = data_out_reg;
    assign last_element = last_reg;
    assign size_error   = err_reg;

endmodule

`default_nettype wire
